@@ rtl/core/rbst_pkg.sv @@
// Shared constants and register map for the ray/box slab test.
`timescale 1ns / 1ps
package rbst_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int NUM_AXES        = 3;
  localparam int REG_IDX_W       = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_EXTENT_X,
    REG_EXTENT_Y,
    REG_EXTENT_Z
  } reg_idx_t;

endpackage

@@ rtl/core/ray_box_slab_test.sv @@
// Pipelined ray against axis-aligned box slab test with an APB register port.
`timescale 1ns / 1ps
// One ray enters per clock: busy is held low, so a beat is taken at every
// edge where start is high. Each ray gives exactly one result beat, shown on
// out_hit for one cycle with out_valid high; the receiver cannot hold results
// off and none is needed. Most of the pipeline depth lies in the six
// restoring dividers, which retire one quotient bit per stage over
// COORD_WIDTH + 1 + FRAC_BITS stages. The box (center and half size per axis)
// sits in APB registers at byte offsets 4*i (8*i when COORD_WIDTH exceeds
// 32); write them only while no ray is in flight. The sign of a half size is
// ignored. A zero direction component marks a parallel axis that passes only
// when the origin lies inside its bounds. Slab parameters saturate and the
// whole line (negative t too) is tested; touching counts as a hit.
module ray_box_slab_test
  import rbst_pkg::*;
#(
  parameter int   COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int   FRAC_BITS   = FRAC_BITS_DEF,
  localparam int  DATA_W      = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int  ASTEP       = (COORD_WIDTH > 32) ? 3 : 2,
  localparam int  ADDR_W      = ASTEP + REG_IDX_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_origin_z,
  input  logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_dir_z,
  output logic                          out_valid,
  output logic                          out_hit,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  localparam int CW  = COORD_WIDTH;
  // dividend is |diff| (CW+1 bits) followed by FRAC_BITS zeros
  localparam int NW  = CW + 1 + FRAC_BITS;
  localparam int NU  = 2 * NUM_AXES;

  localparam logic signed [CW-1:0] T_SAT  = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_NSAT = -T_SAT;

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] cen_r  [NUM_AXES];
  logic signed [CW-1:0] ext_r  [NUM_AXES];
  logic        [CW-1:0] eabs_r [NUM_AXES];
  logic [REG_IDX_W-1:0] widx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign widx   = paddr[ADDR_W-1:ASTEP];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        cen_r[a] <= '0;
        ext_r[a] <= CW'(1) << FRAC_BITS;
      end
    end else if (wr_en) begin
      case (reg_idx_t'(widx))
        REG_CENTER_X: cen_r[0] <= pwdata[CW-1:0];
        REG_CENTER_Y: cen_r[1] <= pwdata[CW-1:0];
        REG_CENTER_Z: cen_r[2] <= pwdata[CW-1:0];
        REG_EXTENT_X: ext_r[0] <= pwdata[CW-1:0];
        REG_EXTENT_Y: ext_r[1] <= pwdata[CW-1:0];
        REG_EXTENT_Z: ext_r[2] <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx_t'(widx))
      REG_CENTER_X: prdata = DATA_W'(cen_r[0]);
      REG_CENTER_Y: prdata = DATA_W'(cen_r[1]);
      REG_CENTER_Z: prdata = DATA_W'(cen_r[2]);
      REG_EXTENT_X: prdata = DATA_W'(ext_r[0]);
      REG_EXTENT_Y: prdata = DATA_W'(ext_r[1]);
      REG_EXTENT_Z: prdata = DATA_W'(ext_r[2]);
      default:      prdata = '0;
    endcase
  end

  // Half size magnitude, held ready ahead of any ray (fits CW bits unsigned)
  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      eabs_r[a] <= ext_r[a][CW-1] ? -ext_r[a] : ext_r[a];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: capture the ray
  // ---------------------------------------------------------------------
  logic                 v1_r;
  logic signed [CW-1:0] o1_r [NUM_AXES];
  logic signed [CW-1:0] d1_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    o1_r[0] <= in_origin_x;
    o1_r[1] <= in_origin_y;
    o1_r[2] <= in_origin_z;
    d1_r[0] <= in_dir_x;
    d1_r[1] <= in_dir_y;
    d1_r[2] <= in_dir_z;
  end

  // ---------------------------------------------------------------------
  // Stage 2: box bounds
  // ---------------------------------------------------------------------
  logic                 v2_r;
  logic signed [CW:0]   mn2_r [NUM_AXES];
  logic signed [CW:0]   mx2_r [NUM_AXES];
  logic signed [CW-1:0] o2_r  [NUM_AXES];
  logic signed [CW-1:0] d2_r  [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      mn2_r[a] <= {cen_r[a][CW-1], cen_r[a]} - {1'b0, eabs_r[a]};
      mx2_r[a] <= {cen_r[a][CW-1], cen_r[a]} + {1'b0, eabs_r[a]};
      o2_r[a]  <= o1_r[a];
      d2_r[a]  <= d1_r[a];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: distances to the bounds, parallel-axis containment
  // ---------------------------------------------------------------------
  logic                 v3_r;
  logic signed [CW+1:0] df3_r [NU];
  logic                 in3_r [NUM_AXES];
  logic signed [CW-1:0] d3_r  [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      df3_r[2*a]   <= {mn2_r[a][CW], mn2_r[a]} - {{2{o2_r[a][CW-1]}}, o2_r[a]};
      df3_r[2*a+1] <= {mx2_r[a][CW], mx2_r[a]} - {{2{o2_r[a][CW-1]}}, o2_r[a]};
      in3_r[a]     <= ($signed({o2_r[a][CW-1], o2_r[a]}) >= mn2_r[a]) &&
                      ($signed({o2_r[a][CW-1], o2_r[a]}) <= mx2_r[a]);
      d3_r[a]      <= d2_r[a];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4 and divider: magnitudes, then one quotient bit per stage
  // ---------------------------------------------------------------------
  logic            vd_r   [NW+1];
  logic [CW-1:0]   dm_r   [NW+1][NUM_AXES];
  logic            par_r  [NW+1][NUM_AXES];
  logic            ok_r   [NW+1][NUM_AXES];
  logic            neg_r  [NW+1][NU];
  logic [CW-1:0]   rem_r  [NW+1][NU];
  logic [CW:0]     nsh_r  [NW+1][NU];
  logic [CW-2:0]   quo_r  [NW+1][NU];
  logic            sat_r  [NW+1][NU];

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r[0] <= 1'b0;
    else        vd_r[0] <= v3_r;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      dm_r[0][a]  <= d3_r[a][CW-1] ? -d3_r[a] : d3_r[a];
      par_r[0][a] <= (d3_r[a] == '0);
      ok_r[0][a]  <= (d3_r[a] != '0) | in3_r[a];
    end
    for (int u = 0; u < NU; u++) begin
      nsh_r[0][u] <= df3_r[u][CW+1] ? (CW+1)'(0) - df3_r[u][CW:0] : df3_r[u][CW:0];
      neg_r[0][u] <= df3_r[u][CW+1] ^ d3_r[u/2][CW-1];
      rem_r[0][u] <= '0;
      quo_r[0][u] <= '0;
      sat_r[0][u] <= 1'b0;
    end
  end

  for (genvar k = 1; k <= NW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) vd_r[k] <= 1'b0;
      else        vd_r[k] <= vd_r[k-1];
    end

    always_ff @(posedge clk) begin
      dm_r[k]  <= dm_r[k-1];
      par_r[k] <= par_r[k-1];
      ok_r[k]  <= ok_r[k-1];
      neg_r[k] <= neg_r[k-1];
    end

    for (genvar u = 0; u < NU; u++) begin : g_unit
      logic [CW:0] r2;
      logic [CW:0] rs;
      logic        ge;

      assign r2 = {rem_r[k-1][u], nsh_r[k-1][u][CW]};
      assign rs = r2 - {1'b0, dm_r[k-1][u/2]};
      assign ge = (r2 >= {1'b0, dm_r[k-1][u/2]});

      // a quotient bit leaving the top means the magnitude exceeds T_SAT
      always_ff @(posedge clk) begin
        rem_r[k][u] <= ge ? rs[CW-1:0] : r2[CW-1:0];
        nsh_r[k][u] <= {nsh_r[k-1][u][CW-1:0], 1'b0};
        quo_r[k][u] <= {quo_r[k-1][u][CW-3:0], ge};
        sat_r[k][u] <= sat_r[k-1][u] | quo_r[k-1][u][CW-2];
      end
    end
  end

  // ---------------------------------------------------------------------
  // P1: saturate and sign the slab parameters
  // ---------------------------------------------------------------------
  logic                 vp1_r;
  logic signed [CW-1:0] t_r    [NU];
  logic                 par1_r [NUM_AXES];
  logic                 ok1_r  [NUM_AXES];
  logic signed [CW-1:0] tm     [NU];

  always_comb begin
    for (int u = 0; u < NU; u++) begin
      tm[u] = sat_r[NW][u] ? T_SAT : $signed({1'b0, quo_r[NW][u]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vp1_r <= 1'b0;
    else        vp1_r <= vd_r[NW];
  end

  always_ff @(posedge clk) begin
    for (int u = 0; u < NU; u++) begin
      t_r[u] <= neg_r[NW][u] ? -tm[u] : tm[u];
    end
    par1_r <= par_r[NW];
    ok1_r  <= ok_r[NW];
  end

  // ---------------------------------------------------------------------
  // P2: order each pair; a parallel axis spans the full range
  // ---------------------------------------------------------------------
  logic                 vp2_r;
  logic signed [CW-1:0] lo2_r [NUM_AXES];
  logic signed [CW-1:0] hi2_r [NUM_AXES];
  logic                 ok2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vp2_r <= 1'b0;
    else        vp2_r <= vp1_r;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (par1_r[a]) begin
        lo2_r[a] <= T_NSAT;
        hi2_r[a] <= T_SAT;
      end else if (t_r[2*a+1] < t_r[2*a]) begin
        lo2_r[a] <= t_r[2*a+1];
        hi2_r[a] <= t_r[2*a];
      end else begin
        lo2_r[a] <= t_r[2*a];
        hi2_r[a] <= t_r[2*a+1];
      end
    end
    ok2_r <= ok1_r[0] & ok1_r[1] & ok1_r[2];
  end

  // ---------------------------------------------------------------------
  // P3, P4: intersect the slabs (x with y, then z)
  // ---------------------------------------------------------------------
  logic                 vp3_r, vp4_r;
  logic signed [CW-1:0] ent3_r, lev3_r, loz3_r, hiz3_r;
  logic signed [CW-1:0] ent4_r, lev4_r;
  logic                 ok3_r, ok4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp3_r <= 1'b0;
      vp4_r <= 1'b0;
    end else begin
      vp3_r <= vp2_r;
      vp4_r <= vp3_r;
    end
  end

  always_ff @(posedge clk) begin
    ent3_r <= (lo2_r[1] > lo2_r[0]) ? lo2_r[1] : lo2_r[0];
    lev3_r <= (hi2_r[1] < hi2_r[0]) ? hi2_r[1] : hi2_r[0];
    loz3_r <= lo2_r[2];
    hiz3_r <= hi2_r[2];
    ok3_r  <= ok2_r;
    ent4_r <= (loz3_r > ent3_r) ? loz3_r : ent3_r;
    lev4_r <= (hiz3_r < lev3_r) ? hiz3_r : lev3_r;
    ok4_r  <= ok3_r;
  end

  // ---------------------------------------------------------------------
  // P5: result beat
  // ---------------------------------------------------------------------
  logic out_valid_r, out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= vp4_r;
  end

  always_ff @(posedge clk) begin
    out_hit_r <= ok4_r & (ent4_r <= lev4_r);
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule
